/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL files of the ICY metadata demux.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never hold at a rising clock edge outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* hw/rtl/icymd_pkg.sv */
// Package for the ICY metadata demux: byte kinds, title matcher phases,
// start pattern table and the title result type. No dependencies.
`timescale 1ns / 1ps

package icymd_pkg;

    // Kind of byte in a result.
    localparam logic [1:0] KIND_AUDIO  = 2'd0;
    localparam logic [1:0] KIND_LENGTH = 2'd1;
    localparam logic [1:0] KIND_TEXT   = 2'd2;

    // Title matcher phases.
    localparam logic [2:0] PH_SEARCH  = 3'd0;
    localparam logic [2:0] PH_TITLE   = 3'd1;
    localparam logic [2:0] PH_QUOTE   = 3'd2;
    localparam logic [2:0] PH_DONE    = 3'd3;
    localparam logic [2:0] PH_ABANDON = 3'd4;
    localparam logic [2:0] PH_STOP    = 3'd5;

    // Length of the start pattern StreamTitle=' in characters.
    localparam logic [3:0] PATTERN_LEN = 4'd13;

    // Special characters of the title syntax.
    localparam logic [7:0] CHAR_QUOTE = 8'h27;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // Title fields produced by the matcher for one text byte.
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] first;
        logic [7:0] second;
        logic       done;
    } title_out_t;

    // Character of the start pattern at a given position.
    function automatic logic [7:0] pattern_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "S";
            4'd1:    c = "t";
            4'd2:    c = "r";
            4'd3:    c = "e";
            4'd4:    c = "a";
            4'd5:    c = "m";
            4'd6:    c = "T";
            4'd7:    c = "i";
            4'd8:    c = "t";
            4'd9:    c = "l";
            4'd10:   c = "e";
            4'd11:   c = "=";
            4'd12:   c = CHAR_QUOTE;
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/icymd_ifs.sv */
// Valid/ready channel interfaces of the ICY metadata demux: stream input,
// result output and configuration write. No dependencies.
`timescale 1ns / 1ps

// Raw stream bytes.
interface icymd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

// One tagged result per stream byte.
interface icymd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] byte_kind;
    logic [7:0] data_byte;
    logic       meta_last;
    logic [1:0] title_count;
    logic [7:0] title_first;
    logic [7:0] title_second;
    logic       title_done;
    logic       title_dropped;

    modport source (output valid, output byte_kind, output data_byte, output meta_last,
                    output title_count, output title_first, output title_second,
                    output title_done, output title_dropped, input ready);
    modport sink   (input valid, input byte_kind, input data_byte, input meta_last,
                    input title_count, input title_first, input title_second,
                    input title_done, input title_dropped, output ready);
endinterface

// Write channel of the metadata interval register.
interface icymd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] meta_interval;

    modport source (output valid, output meta_interval, input ready);
    modport sink   (input valid, input meta_interval, output ready);
endinterface

/* hw/rtl/icymd_title_match.sv */
// Title matcher of the ICY metadata demux: next matcher state and title
// fields for one metadata text byte. Depends on icymd_pkg.
`timescale 1ns / 1ps

module icymd_title_match
    import icymd_pkg::*;
(
    input  logic [7:0] text_byte,
    input  logic [2:0] phase,
    input  logic [3:0] match_pos,
    output logic [2:0] phase_next,
    output logic [3:0] match_pos_next,
    output title_out_t title
);

    logic       pattern_hit;
    logic [3:0] pos_inc;

    assign pattern_hit = (match_pos < PATTERN_LEN) && (text_byte == pattern_char(match_pos));
    assign pos_inc     = match_pos + 4'd1;

    // Search for the start pattern, then pass title characters and hold
    // a quote back until the following byte shows whether it closes.
    always_comb
    begin
        phase_next     = phase;
        match_pos_next = match_pos;
        title          = '0;
        case (phase)
            PH_SEARCH:
            begin
                if (text_byte == CHAR_NUL)
                begin
                    phase_next     = PH_STOP;
                    match_pos_next = 4'd0;
                end
                else if (pattern_hit)
                begin
                    if (pos_inc >= PATTERN_LEN)
                    begin
                        match_pos_next = 4'd0;
                        phase_next     = PH_TITLE;
                    end
                    else
                    begin
                        match_pos_next = pos_inc;
                    end
                end
                else
                begin
                    // A mismatching byte may still open a new attempt.
                    match_pos_next = (text_byte == pattern_char(4'd0)) ? 4'd1 : 4'd0;
                end
            end
            PH_TITLE:
            begin
                if (text_byte == CHAR_NUL)
                begin
                    phase_next = PH_ABANDON;
                end
                else if (text_byte == CHAR_QUOTE)
                begin
                    phase_next = PH_QUOTE;
                end
                else
                begin
                    title.count = 2'd1;
                    title.first = text_byte;
                end
            end
            PH_QUOTE:
            begin
                if (text_byte == CHAR_NUL)
                begin
                    phase_next = PH_ABANDON;
                end
                else if (text_byte == CHAR_SEMI)
                begin
                    phase_next = PH_DONE;
                    title.done = 1'b1;
                end
                else if (text_byte == CHAR_QUOTE)
                begin
                    // The held quote is a title character; the new one is held.
                    title.count = 2'd1;
                    title.first = CHAR_QUOTE;
                end
                else
                begin
                    title.count  = 2'd2;
                    title.first  = CHAR_QUOTE;
                    title.second = text_byte;
                    phase_next   = PH_TITLE;
                end
            end
            default:
            begin
                phase_next = phase;
            end
        endcase
    end

endmodule

/* hw/rtl/icy_metadata_stream_demux.sv */
// Top level of the ICY metadata demux: input register, byte classifier,
// title matcher and result register. Depends on icymd_pkg, icymd_ifs and
// icymd_title_match.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The block takes one stream byte per cycle and gives one tagged result per
// byte, also one per cycle while results are taken. A byte sits in the input
// register while the counters and the title matcher work on it, and its
// result is then presented by the result register until it is transferred.
// A result that is not taken stalls the input once both registers are full.
// meta_interval audio bytes are followed by a length byte
// and that many 16-byte units of text, which is searched for StreamTitle='.
// An interval of zero passes every byte as audio. Writing the interval also
// reloads the audio byte counter; write it only while no byte is in flight.

module icy_metadata_stream_demux
    import icymd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    icymd_in_if.sink    stream,
    icymd_out_if.source result,
    icymd_cfg_if.sink   cfg
);

    // Configuration and demux state.
    logic [15:0] meta_interval_reg;
    logic [15:0] audio_count_reg, audio_count_next;
    logic        in_meta_reg, in_meta_next;
    logic [11:0] meta_left_reg, meta_left_next;
    logic [3:0]  match_pos_reg, match_pos_next;
    logic [2:0]  phase_reg, phase_next;

    // Input stage.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // Result stage.
    logic        res_valid_reg;
    logic [1:0]  res_kind_reg, res_kind_next;
    logic [7:0]  res_byte_reg;
    logic        res_last_reg, res_last_next;
    title_out_t  res_title_reg, res_title_next;
    logic        res_dropped_reg, res_dropped_next;

    // Matcher outputs and helper values.
    logic [2:0]  mt_phase;
    logic [3:0]  mt_pos;
    title_out_t  mt_title;
    logic [11:0] left_dec;
    logic        advance;
    logic        in_take;

    // Pipeline handshake: a byte moves to the result stage when that
    // stage is empty or its result is being transferred.
    assign advance      = in_valid_reg && (!res_valid_reg || result.ready);
    assign stream.ready = !in_valid_reg || advance;
    assign in_take      = stream.valid && stream.ready;
    assign cfg.ready    = 1'b1;

    icymd_title_match u_match (
        .text_byte      (in_byte_reg),
        .phase          (phase_reg),
        .match_pos      (match_pos_reg),
        .phase_next     (mt_phase),
        .match_pos_next (mt_pos),
        .title          (mt_title)
    );

    assign left_dec = meta_left_reg - 12'd1;

    // Classify the byte and compute the next demux state.
    always_comb
    begin
        audio_count_next = audio_count_reg;
        in_meta_next     = in_meta_reg;
        meta_left_next   = meta_left_reg;
        match_pos_next   = match_pos_reg;
        phase_next       = phase_reg;
        res_kind_next    = KIND_AUDIO;
        res_last_next    = 1'b0;
        res_title_next   = '0;
        res_dropped_next = 1'b0;

        if (meta_interval_reg == 16'd0)
        begin
            in_meta_next   = 1'b0;
            meta_left_next = 12'd0;
            match_pos_next = 4'd0;
            phase_next     = PH_SEARCH;
        end
        else if (in_meta_reg)
        begin
            res_kind_next  = KIND_TEXT;
            res_title_next = mt_title;
            phase_next     = mt_phase;
            match_pos_next = mt_pos;
            meta_left_next = left_dec;
            if (left_dec == 12'd0)
            begin
                // End of the text block: flag an unfinished title.
                res_last_next    = 1'b1;
                res_dropped_next = mt_phase inside {PH_TITLE, PH_QUOTE, PH_ABANDON};
                in_meta_next     = 1'b0;
                audio_count_next = meta_interval_reg;
                match_pos_next   = 4'd0;
                phase_next       = PH_SEARCH;
            end
        end
        else if (audio_count_reg == 16'd0)
        begin
            res_kind_next = KIND_LENGTH;
            if (in_byte_reg == CHAR_NUL)
            begin
                res_last_next    = 1'b1;
                audio_count_next = meta_interval_reg;
            end
            else
            begin
                meta_left_next = {in_byte_reg, 4'b0000};
                in_meta_next   = 1'b1;
                match_pos_next = 4'd0;
                phase_next     = PH_SEARCH;
            end
        end
        else
        begin
            audio_count_next = audio_count_reg - 16'd1;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_interval_reg <= 16'd0;
            audio_count_reg   <= 16'd0;
            in_meta_reg       <= 1'b0;
            meta_left_reg     <= 12'd0;
            match_pos_reg     <= 4'd0;
            phase_reg         <= PH_SEARCH;
            in_valid_reg      <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                in_meta_reg     <= in_meta_next;
                meta_left_reg   <= meta_left_next;
                match_pos_reg   <= match_pos_next;
                phase_reg       <= phase_next;
            end
            // A register write reloads the audio counter.
            if (cfg.valid && cfg.ready)
            begin
                meta_interval_reg <= cfg.meta_interval;
                audio_count_reg   <= cfg.meta_interval;
            end
            else if (advance)
            begin
                audio_count_reg <= audio_count_next;
            end
            if (stream.ready)
            begin
                in_valid_reg <= stream.valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= stream.stream_byte;
        end
        if (advance)
        begin
            res_kind_reg    <= res_kind_next;
            res_byte_reg    <= in_byte_reg;
            res_last_reg    <= res_last_next;
            res_title_reg   <= res_title_next;
            res_dropped_reg <= res_dropped_next;
        end
    end

    // Result channel.
    assign result.valid         = res_valid_reg;
    assign result.byte_kind     = res_kind_reg;
    assign result.data_byte     = res_byte_reg;
    assign result.meta_last     = res_last_reg;
    assign result.title_count   = res_title_reg.count;
    assign result.title_first   = res_title_reg.first;
    assign result.title_second  = res_title_reg.second;
    assign result.title_done    = res_title_reg.done;
    assign result.title_dropped = res_dropped_reg;

    // Title fields appear only on metadata text bytes.
    `ASSERT_CLK(a_title_only_text,
        result.valid && (result.byte_kind != KIND_TEXT) |->
            (result.title_count == 2'd0) && !result.title_done && !result.title_dropped,
        "title fields set on a non-text byte")
    // A metadata block in progress always has text bytes left.
    `ASSERT_NEVER(a_meta_left_nonzero, in_meta_reg && (meta_left_reg == 12'd0),
        "metadata phase with no text bytes left")
    // The pattern position never runs past the pattern.
    `ASSERT_NEVER(a_match_pos_range, match_pos_reg >= PATTERN_LEN,
        "start pattern position out of range")
    // The closing sequence confirms no title character.
    `ASSERT_CLK(a_done_no_chars,
        result.valid && result.title_done |-> (result.title_count == 2'd0),
        "title done together with title characters")

endmodule

/* sim/tb_icy_metadata_stream_demux.sv */
// Self-checking testbench for icy_metadata_stream_demux: directed table, then random
// metadata frames, checked against a cycle-free predictor of the demux.
// Depends on icymd_pkg, icymd_ifs and the RTL of the block.
`timescale 1ns / 1ps

module tb_icy_metadata_stream_demux;
    import icymd_pkg::*;

    // One tagged result, in the order of the output fields.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic [1:0] count;
        logic [7:0] first;
        logic [7:0] second;
        logic       done;
        logic       dropped;
    } demux_result_t;

    // One row of the directed table: a register write or a stream byte.
    typedef struct packed {
        logic          is_cfg;
        logic [15:0]   value;
        logic          typed;
        demux_result_t want;
    } stim_row_t;

    localparam logic [8*13-1:0] TITLE_KEY = "StreamTitle='";
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int NUM_PHASES = 10;
    localparam int PRESSURE_PHASE = 6;

    // Random phases: interval, idle percentages, length and interval rewrites.
    int phase_interval[NUM_PHASES] = '{1, 3, 8, 2, 65535, 0, 4, 1, 16, 5};
    int phase_send_pct[NUM_PHASES] = '{0, 59, 0, 21, 0, 59, 0, 0, 21, 59};
    int phase_recv_pct[NUM_PHASES] = '{0, 0, 59, 21, 0, 0, 0, 59, 21, 0};
    int phase_items[NUM_PHASES] = '{150, 150, 150, 150, 30, 60, 150, 150, 150, 130};
    bit phase_rewrite[NUM_PHASES] = '{0, 0, 0, 0, 0, 0, 0, 1, 0, 1};

    logic clk = 1'b0;
    logic rst_n;

    icymd_in_if  in_ch();
    icymd_out_if out_ch();
    icymd_cfg_if cfg_ch();

    icy_metadata_stream_demux u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (in_ch),
        .result (out_ch),
        .cfg    (cfg_ch)
    );

    // Predictor state of the demux.
    logic [15:0] cur_interval;
    logic [15:0] audio_left;
    logic        in_text;
    logic [11:0] text_left;
    logic [3:0]  match_len;
    logic [2:0]  title_state;

    demux_result_t pending_results[$];
    logic [7:0]    text_script[$];
    stim_row_t     directed_rows[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_requests = 0;

    always #5 clk = ~clk;

    function automatic logic [7:0] key_char(input int i);
        return TITLE_KEY[8 * (PATTERN_LEN - 1 - i) +: 8];
    endfunction

    function automatic demux_result_t outcome(input logic [1:0] kind, input logic [7:0] data,
                                              input logic last, input logic [1:0] count,
                                              input logic [7:0] first, input logic [7:0] second,
                                              input logic done, input logic dropped);
        demux_result_t r;
        r = '{kind, data, last, count, first, second, done, dropped};
        return r;
    endfunction

    function automatic stim_row_t row(input logic is_cfg, input logic [15:0] value,
                                      input logic typed, input demux_result_t want);
        stim_row_t s;
        s = '{is_cfg, value, typed, want};
        return s;
    endfunction

    // Expected result of one stream byte; advances the predictor state.
    function automatic demux_result_t classify_byte(input logic [7:0] b);
        demux_result_t r;
        r = '0;
        r.kind = KIND_AUDIO;
        r.data = b;
        if (cur_interval == 16'd0) begin
            // Pass-through: any open block and title search are dropped silently.
            in_text = 1'b0;
            text_left = '0;
            match_len = '0;
            title_state = PH_SEARCH;
        end else if (in_text) begin
            r.kind = KIND_TEXT;
            case (title_state)
                PH_SEARCH: begin
                    if (b == CHAR_NUL) begin
                        title_state = PH_STOP;
                        match_len = '0;
                    end else if (b == key_char(match_len)) begin
                        if (match_len == PATTERN_LEN - 4'd1) begin
                            match_len = '0;
                            title_state = PH_TITLE;
                        end else begin
                            match_len = match_len + 4'd1;
                        end
                    end else begin
                        match_len = (b == key_char(0)) ? 4'd1 : 4'd0;
                    end
                end
                PH_TITLE: begin
                    if (b == CHAR_NUL) begin
                        title_state = PH_ABANDON;
                    end else if (b == CHAR_QUOTE) begin
                        title_state = PH_QUOTE;
                    end else begin
                        r.count = 2'd1;
                        r.first = b;
                    end
                end
                PH_QUOTE: begin
                    // The held quote is resolved by the byte after it.
                    if (b == CHAR_NUL) begin
                        title_state = PH_ABANDON;
                    end else if (b == CHAR_SEMI) begin
                        title_state = PH_DONE;
                        r.done = 1'b1;
                    end else if (b == CHAR_QUOTE) begin
                        r.count = 2'd1;
                        r.first = CHAR_QUOTE;
                    end else begin
                        r.count = 2'd2;
                        r.first = CHAR_QUOTE;
                        r.second = b;
                        title_state = PH_TITLE;
                    end
                end
                default: ;
            endcase
            text_left = text_left - 12'd1;
            if (text_left == 12'd0) begin
                r.last = 1'b1;
                r.dropped = (title_state == PH_TITLE) || (title_state == PH_QUOTE) ||
                            (title_state == PH_ABANDON);
                in_text = 1'b0;
                audio_left = cur_interval;
                match_len = '0;
                title_state = PH_SEARCH;
            end
        end else if (audio_left == 16'd0) begin
            r.kind = KIND_LENGTH;
            if (b == CHAR_NUL) begin
                r.last = 1'b1;
                audio_left = cur_interval;
            end else begin
                text_left = {b, 4'b0000};
                in_text = 1'b1;
                match_len = '0;
                title_state = PH_SEARCH;
            end
        end else begin
            audio_left = audio_left - 16'd1;
        end
        return r;
    endfunction

    // Metadata text of n bytes: mostly a title entry with random content, some noise.
    function automatic void build_text(input int n);
        int style;
        int bad;
        int r;
        text_script.delete();
        style = $urandom_range(0, 9);
        if (style == 0) begin
            repeat (n) text_script.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 3))
                text_script.push_back(($urandom_range(0, 1) != 0) ? key_char(0)
                                                                   : 8'($urandom_range(32, 126)));
            // The start pattern, now and then with one character broken.
            bad = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 12) : -1;
            for (int i = 0; i < PATTERN_LEN; i++)
                text_script.push_back((i == bad) ? 8'($urandom_range(32, 126)) : key_char(i));
            repeat ($urandom_range(0, 14)) begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    text_script.push_back(CHAR_QUOTE);
                end else if (r < 20) begin
                    text_script.push_back(CHAR_SEMI);
                end else if (r < 23) begin
                    text_script.push_back(CHAR_NUL);
                end else if (r < 27) begin
                    text_script.push_back(CHAR_QUOTE);
                    text_script.push_back(CHAR_QUOTE);
                end else if (r < 90) begin
                    text_script.push_back(8'($urandom_range(32, 126)));
                end else begin
                    text_script.push_back(8'($urandom_range(1, 255)));
                end
            end
            // Closing sequence: proper, missing, lone quote, zero byte or doubled quote.
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    text_script.push_back(CHAR_QUOTE);
                    text_script.push_back(CHAR_SEMI);
                end
                6: ;
                7: text_script.push_back(CHAR_QUOTE);
                8: text_script.push_back(CHAR_NUL);
                default: begin
                    text_script.push_back(CHAR_QUOTE);
                    text_script.push_back(CHAR_QUOTE);
                    text_script.push_back(CHAR_SEMI);
                end
            endcase
            while (text_script.size() < n)
                text_script.push_back(style[0] ? CHAR_NUL : 8'($urandom_range(32, 126)));
        end
        while (text_script.size() > n) void'(text_script.pop_back());
    endfunction

    // Next stream byte, chosen from where the predictor says the stream stands.
    function automatic logic [7:0] next_stream_byte();
        logic [7:0] b;
        int r;
        if (cur_interval != 16'd0 && in_text) begin
            b = (text_script.size() != 0) ? text_script.pop_front() : 8'($urandom_range(0, 255));
        end else if (cur_interval != 16'd0 && audio_left == 16'd0) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                b = 8'd0;
            end else if (r < 85) begin
                b = 8'($urandom_range(1, 3));
            end else if (r < 97) begin
                b = 8'($urandom_range(4, 8));
            end else begin
                b = 8'($urandom_range(9, 20));
            end
            build_text(int'(b) * 16);
        end else begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    // Sends one stream byte after a random gap and records its expected result.
    task automatic send_byte(input logic [7:0] b, input logic typed, input demux_result_t want);
        demux_result_t predicted;
        predicted = classify_byte(b);
        pending_results.push_back(typed ? want : predicted);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.stream_byte <= b;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Writes the interval once every byte in flight has produced its result.
    task automatic write_interval(input logic [15:0] v);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.meta_interval <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        cur_interval = v;
        audio_left = v;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got, input logic [7:0] data);
        if (got !== want) begin
            $display("%0t: %s on byte %02h: expected %02h, got %02h",
                     $time, name, data, want, got);
            mismatch_count++;
        end
    endtask

    // Result receiver: random stalls, plus a long hold-off on request.
    initial begin
        int hold_left;
        int seen;
        hold_left = 0;
        seen = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_requests != seen) begin
                seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Every result transfer is compared with the oldest expectation.
    always @(posedge clk) begin
        demux_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: expected nothing, got byte %02h kind %0d",
                         $time, out_ch.data_byte, out_ch.byte_kind);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("byte_kind", 8'(want.kind), 8'(out_ch.byte_kind), want.data);
                check_field("data_byte", want.data, out_ch.data_byte, want.data);
                check_field("meta_last", 8'(want.last), 8'(out_ch.meta_last), want.data);
                check_field("title_count", 8'(want.count), 8'(out_ch.title_count), want.data);
                check_field("title_first", want.first, out_ch.title_first, want.data);
                check_field("title_second", want.second, out_ch.title_second, want.data);
                check_field("title_done", 8'(want.done), 8'(out_ch.title_done), want.data);
                check_field("title_dropped", 8'(want.dropped), 8'(out_ch.title_dropped),
                            want.data);
            end
        end
    end

    // Run limit.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus: reset, directed table, random phases, drain.
    initial begin
        int guard;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.stream_byte = 8'd0;
        cfg_ch.valid = 1'b0;
        cfg_ch.meta_interval = 16'd0;
        cur_interval = '0;
        audio_left = '0;
        in_text = 1'b0;
        text_left = '0;
        match_len = '0;
        title_state = PH_SEARCH;

        // Directed table: pass-through after reset, the largest interval, a zero
        // length byte, then one block that ends inside the title, on a doubled quote
        // at the last text byte.
        directed_rows.push_back(row(1'b0, 16'h00, 1'b1, outcome(KIND_AUDIO, 8'h00, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(row(1'b0, 16'hFF, 1'b1, outcome(KIND_AUDIO, 8'hFF, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(row(1'b0, 16'h27, 1'b1, outcome(KIND_AUDIO, 8'h27, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(row(1'b1, 16'hFFFF, 1'b0, '0));
        directed_rows.push_back(row(1'b0, 16'h5A, 1'b1, outcome(KIND_AUDIO, 8'h5A, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(row(1'b0, 16'hA5, 1'b1, outcome(KIND_AUDIO, 8'hA5, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(row(1'b1, 16'h0001, 1'b0, '0));
        directed_rows.push_back(row(1'b0, 16'h80, 1'b1, outcome(KIND_AUDIO, 8'h80, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(row(1'b0, 16'h00, 1'b1, outcome(KIND_LENGTH, 8'h00, 1, 0, 0, 0, 0, 0)));
        directed_rows.push_back(row(1'b0, 16'h7F, 1'b1, outcome(KIND_AUDIO, 8'h7F, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(row(1'b0, 16'h01, 1'b1, outcome(KIND_LENGTH, 8'h01, 0, 0, 0, 0, 0, 0)));
        for (int i = 0; i < PATTERN_LEN; i++)
            directed_rows.push_back(row(1'b0, 16'(key_char(i)), 1'b0, '0));
        directed_rows.push_back(row(1'b0, 16'h61, 1'b0, '0));
        directed_rows.push_back(row(1'b0, 16'(CHAR_QUOTE), 1'b0, '0));
        directed_rows.push_back(row(1'b0, 16'(CHAR_QUOTE), 1'b1,
                                    outcome(KIND_TEXT, CHAR_QUOTE, 1, 1, CHAR_QUOTE, 0, 0, 1)));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg)
                write_interval(directed_rows[i].value);
            else
                send_byte(directed_rows[i].value[7:0], directed_rows[i].typed,
                          directed_rows[i].want);
        end

        // Random phases; one of them holds the receiver off while bytes keep coming.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_interval(16'(phase_interval[p]));
            send_idle_pct = phase_send_pct[p];
            recv_stall_pct = phase_recv_pct[p];
            if (p == PRESSURE_PHASE)
                hold_requests++;
            for (int k = 0; k < phase_items[p]; k++) begin
                // Interval rewrites land between bytes, often in the middle of a block.
                if (phase_rewrite[p] && $urandom_range(0, 24) == 0)
                    write_interval(($urandom_range(0, 2) == 0) ? 16'd0
                                                               : 16'($urandom_range(1, 6)));
                send_byte(next_stream_byte(), 1'b0, '0);
            end
        end

        // Drain the remaining results, then allow for the pipeline latency.
        in_ch.valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(negedge clk);
            guard++;
        end
        repeat (8) @(negedge clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            mismatch_count += pending_results.size();
        end

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
